>>> src/svk_cauchy_stress_assert.svh
// Assertion macros shared by the stress block.
// Each macro checks on the rising edge of clk and is held off during rst.
`ifndef SVK_CAUCHY_STRESS_ASSERT_SVH
`define SVK_CAUCHY_STRESS_ASSERT_SVH

// Same-cycle implication.
`define SVK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SVK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/svk_pkg.sv
// ----------------------------------------------------------------------------
// svk_pkg
// Shared constants and helpers for the St. Venant-Kirchhoff stress pipeline.
// ----------------------------------------------------------------------------
package svk_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 24;

  localparam int LAM_W = 32;
  localparam int MU_W  = 31;

  // Stress components, in output order xx, yy, zz, xy, yz, xz.
  localparam int NL = 6;
  localparam int ROW [NL] = '{0, 1, 2, 0, 1, 0};
  localparam int COL [NL] = '{0, 1, 2, 1, 2, 2};

  // Register index codes, taken from address bit 2.
  localparam logic [0:0] REG_LAMBDA = 1'b0;
  localparam logic [0:0] REG_MU     = 1'b1;

  // Map a symmetric tensor position onto its component index.
  function automatic int sym_idx(int a, int c);
    if (a == c) begin
      return a;
    end else if (a + c == 1) begin
      return 3;
    end else if (a + c == 3) begin
      return 4;
    end else begin
      return 5;
    end
  endfunction

  function automatic int max2(int x, int y);
    return (x > y) ? x : y;
  endfunction

endpackage

>>> src/svk_point_if.sv
// ----------------------------------------------------------------------------
// svk_point_if
// Material point channel: deformation gradient and volume ratio.
// ----------------------------------------------------------------------------
interface svk_point_if #(
  parameter int DATA_WIDTH = svk_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] f_11;
  logic signed [DATA_WIDTH-1:0] f_12;
  logic signed [DATA_WIDTH-1:0] f_13;
  logic signed [DATA_WIDTH-1:0] f_21;
  logic signed [DATA_WIDTH-1:0] f_22;
  logic signed [DATA_WIDTH-1:0] f_23;
  logic signed [DATA_WIDTH-1:0] f_31;
  logic signed [DATA_WIDTH-1:0] f_32;
  logic signed [DATA_WIDTH-1:0] f_33;
  logic        [DATA_WIDTH-2:0] volume_ratio;

  modport source (
    output valid, f_11, f_12, f_13, f_21, f_22, f_23, f_31, f_32, f_33, volume_ratio,
    input  ready
  );

  modport sink (
    input  valid, f_11, f_12, f_13, f_21, f_22, f_23, f_31, f_32, f_33, volume_ratio,
    output ready
  );
endinterface

>>> src/svk_stress_if.sv
// ----------------------------------------------------------------------------
// svk_stress_if
// Cauchy stress result channel with saturation flag.
// ----------------------------------------------------------------------------
interface svk_stress_if #(
  parameter int DATA_WIDTH = svk_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sigma_xx;
  logic signed [DATA_WIDTH-1:0] sigma_yy;
  logic signed [DATA_WIDTH-1:0] sigma_zz;
  logic signed [DATA_WIDTH-1:0] sigma_xy;
  logic signed [DATA_WIDTH-1:0] sigma_yz;
  logic signed [DATA_WIDTH-1:0] sigma_xz;
  logic                         saturated;

  modport source (
    output valid, sigma_xx, sigma_yy, sigma_zz, sigma_xy, sigma_yz, sigma_xz, saturated,
    input  ready
  );

  modport sink (
    input  valid, sigma_xx, sigma_yy, sigma_zz, sigma_xy, sigma_yz, sigma_xz, saturated,
    output ready
  );
endinterface

>>> src/svk_wmul.sv
// ----------------------------------------------------------------------------
// svk_wmul
// Signed wide multiplier: 33x33 limb products in one stage, sum in the next.
// ----------------------------------------------------------------------------
module svk_wmul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int LW = 32;
  localparam int NA = (AW + LW - 1) / LW;
  localparam int NB = (BW + LW - 1) / LW;
  localparam int PW = AW + BW;

  logic signed [NA*LW-1:0] a_ext;
  logic signed [NB*LW-1:0] b_ext;
  logic signed [LW:0]      la [NA];
  logic signed [LW:0]      lb [NB];
  logic signed [2*LW+1:0]  pp [NA][NB];
  logic signed [PW-1:0]    acc;

  assign a_ext = (NA*LW)'(a);
  assign b_ext = (NB*LW)'(b);

  // Lower limbs are unsigned, the top limb carries the sign.
  for (genvar gi = 0; gi < NA; gi++) begin : g_la
    assign la[gi] = {(gi == NA - 1) ? a_ext[LW*gi+LW-1] : 1'b0, a_ext[LW*gi +: LW]};
  end
  for (genvar gj = 0; gj < NB; gj++) begin : g_lb
    assign lb[gj] = {(gj == NB - 1) ? b_ext[LW*gj+LW-1] : 1'b0, b_ext[LW*gj +: LW]};
  end

  for (genvar gi = 0; gi < NA; gi++) begin : g_pi
    for (genvar gj = 0; gj < NB; gj++) begin : g_pj
      always_ff @(posedge clk) begin
        if (en) begin
          pp[gi][gj] <= la[gi] * lb[gj];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp[i][j]) <<< (LW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc;
    end
  end

endmodule

>>> src/svk_div.sv
// ----------------------------------------------------------------------------
// svk_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor.
// ----------------------------------------------------------------------------
module svk_div #(
  parameter int DATA_WIDTH = svk_pkg::DATA_WIDTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic [DATA_WIDTH-2:0]                     j0,
  input  logic [svk_pkg::NL-1:0][DATA_WIDTH-2:0]    rem0,
  input  logic [svk_pkg::NL-1:0][DATA_WIDTH-2:0]    dvd0,
  output logic [svk_pkg::NL-1:0][DATA_WIDTH-2:0]    q
);

  localparam int QW    = DATA_WIDTH - 1;
  localparam int STEPS = QW;
  localparam int NL    = svk_pkg::NL;

  logic [QW-1:0]          jr [1:STEPS-1];
  logic [NL-1:0][QW-1:0]  rr [1:STEPS-1];
  logic [NL-1:0][QW-1:0]  dr [1:STEPS-1];
  logic [NL-1:0][QW-1:0]  qr [1:STEPS];

  logic [QW-1:0]          src_j [STEPS];
  logic [NL-1:0][QW-1:0]  src_r [STEPS];
  logic [NL-1:0][QW-1:0]  src_d [STEPS];
  logic [NL-1:0][QW-1:0]  src_q [STEPS];
  logic [QW:0]            trial [STEPS][NL];
  logic [QW+1:0]          diff  [STEPS][NL];
  logic [NL-1:0]          take  [STEPS];
  logic [QW-1:0]          rnew  [STEPS][NL];

  always_comb begin
    for (int s = 0; s < STEPS; s++) begin
      if (s == 0) begin
        src_j[s] = j0;
        src_r[s] = rem0;
        src_d[s] = dvd0;
        src_q[s] = '0;
      end else begin
        src_j[s] = jr[s];
        src_r[s] = rr[s];
        src_d[s] = dr[s];
        src_q[s] = qr[s];
      end
      for (int l = 0; l < NL; l++) begin
        trial[s][l] = {src_r[s][l], src_d[s][l][QW-1]};
        diff[s][l]  = {1'b0, trial[s][l]} - {2'b00, src_j[s]};
        take[s][l]  = !diff[s][l][QW+1];
        rnew[s][l]  = take[s][l] ? diff[s][l][QW-1:0] : trial[s][l][QW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STEPS; s++) begin
        for (int l = 0; l < NL; l++) begin
          qr[s+1][l] <= {src_q[s][l][QW-2:0], take[s][l]};
        end
        if (s < STEPS - 1) begin
          jr[s+1] <= src_j[s];
          for (int l = 0; l < NL; l++) begin
            rr[s+1][l] <= rnew[s][l];
            dr[s+1][l] <= {src_d[s][l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign q = qr[STEPS];

endmodule

>>> src/svk_cauchy_stress.sv
// ----------------------------------------------------------------------------
// svk_cauchy_stress
// St. Venant-Kirchhoff Cauchy stress, one material point per beat.
//
// Points arrive on the points channel (nine F entries and J, Q8.24); stress
// beats leave on the stress channel (six components, Q16.16, and a flag set
// when any component was clipped). lame_lambda (0x0) and lame_mu (0x4) are
// written over APB only while the pipeline is empty; the user keeps to this,
// as the block does not enforce it. Reads return their values. The pipeline
// takes one point per cycle while the skid register is empty. A point passes
// ten stages of limb multipliers and adders forming b, b^2, the trace term and
// the numerators, one stage preparing the division, DATA_WIDTH - 1 stages of
// the divider by J with one quotient bit each, and one output register.
// Reset clears lambda, mu and the valid bits of the pipeline, output and skid;
// the pipeline is empty right after. When the receiver stalls, one more beat
// parks in a skid register; the whole pipeline holds until the skid drains.
// ----------------------------------------------------------------------------
`include "svk_cauchy_stress_assert.svh"

module svk_cauchy_stress #(
  parameter int DATA_WIDTH      = svk_pkg::DATA_WIDTH_DEF,
  parameter int INPUT_FRAC_BITS = svk_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  svk_point_if.sink   points,
  svk_stress_if.source stress
);

  localparam int D     = DATA_WIDTH;
  localparam int FB    = INPUT_FRAC_BITS;
  localparam int NL    = svk_pkg::NL;
  localparam int LAM_W = svk_pkg::LAM_W;
  localparam int MU_W  = svk_pkg::MU_W;
  localparam int FPW   = 2 * D;
  localparam int BW    = 2 * D + 2;
  localparam int TW    = svk_pkg::max2(2 * D + 3, 2 * FB + 2) + 1;
  localparam int LTW   = LAM_W + TW;
  localparam int KW    = svk_pkg::max2(LTW, MU_W + 2 * FB + 2) + 1;
  localparam int SQPW  = 2 * BW;
  localparam int SQW   = SQPW + 2;
  localparam int MU2W  = MU_W + 2;
  localparam int SMW   = SQW + MU2W;
  localparam int BKW   = BW + KW;
  localparam int NW    = svk_pkg::max2(SMW, BKW) + 1;
  localparam int SH    = 3 * FB + 1;
  localparam int MW    = svk_pkg::max2(NW, SH + 2 * D);
  localparam int HW    = MW - SH - D + 1;
  localparam int QW    = D - 1;
  localparam int PL    = D + 10;

  // Configuration registers
  logic signed [LAM_W-1:0] lame_lambda;
  logic        [MU_W-1:0]  lame_mu;

  always_ff @(posedge clk) begin
    if (rst) begin
      lame_lambda <= '0;
      lame_mu     <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        svk_pkg::REG_LAMBDA: lame_lambda <= pwdata;
        svk_pkg::REG_MU:     lame_mu     <= pwdata[MU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      svk_pkg::REG_LAMBDA: prdata = lame_lambda;
      svk_pkg::REG_MU:     prdata = {1'b0, lame_mu};
      default:             prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Pipeline control
  logic          en;
  logic [PL:1]   v;
  logic          out_v;
  logic          skid_v;

  assign en           = !skid_v;
  assign points.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[PL-1:1], points.valid};
    end
  end

  logic signed [D-1:0] fin [9];
  assign fin[0] = points.f_11;
  assign fin[1] = points.f_12;
  assign fin[2] = points.f_13;
  assign fin[3] = points.f_21;
  assign fin[4] = points.f_22;
  assign fin[5] = points.f_23;
  assign fin[6] = points.f_31;
  assign fin[7] = points.f_32;
  assign fin[8] = points.f_33;

  // Stages 1-2: F row products
  logic signed [FPW-1:0] fp [NL][3];
  for (genvar gu = 0; gu < NL; gu++) begin : g_ff
    for (genvar ge = 0; ge < 3; ge++) begin : g_e
      svk_wmul #(.AW(D), .BW(D)) u_mul (
        .clk (clk),
        .en  (en),
        .a   (fin[svk_pkg::ROW[gu]*3+ge]),
        .b   (fin[svk_pkg::COL[gu]*3+ge]),
        .p   (fp[gu][ge])
      );
    end
  end

  // Volume ratio travels alongside until the divider
  logic [QW-1:0] jp [1:10];
  always_ff @(posedge clk) begin
    if (en) begin
      jp[1] <= points.volume_ratio;
      for (int s = 2; s <= 10; s++) begin
        jp[s] <= jp[s-1];
      end
    end
  end

  // Stage 3: b, stage 4: 2*trE, b delayed to stage 7
  logic signed [BW-1:0] b3 [NL];
  logic signed [BW-1:0] b4 [NL];
  logic signed [BW-1:0] b5 [NL];
  logic signed [BW-1:0] b6 [NL];
  logic signed [BW-1:0] b7 [NL];
  logic signed [TW-1:0] tr4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int u = 0; u < NL; u++) begin
        b3[u] <= BW'(fp[u][0]) + BW'(fp[u][1]) + BW'(fp[u][2]);
      end
      tr4 <= TW'(b3[0]) + TW'(b3[1]) + TW'(b3[2]) - (TW'(3) << (2 * FB));
      b4  <= b3;
      b5  <= b4;
      b6  <= b5;
      b7  <= b6;
    end
  end

  // Stages 5-6: lambda * 2trE and the b^2 products
  logic signed [LTW-1:0]  lt6;
  logic signed [SQPW-1:0] sqp [NL][3];

  svk_wmul #(.AW(LAM_W), .BW(TW)) u_lam (
    .clk (clk),
    .en  (en),
    .a   (lame_lambda),
    .b   (tr4),
    .p   (lt6)
  );

  for (genvar gu = 0; gu < NL; gu++) begin : g_sq
    for (genvar ge = 0; ge < 3; ge++) begin : g_e
      localparam int IA = svk_pkg::sym_idx(svk_pkg::ROW[gu], ge);
      localparam int IB = svk_pkg::sym_idx(ge, svk_pkg::COL[gu]);
      svk_wmul #(.AW(BW), .BW(BW)) u_mul (
        .clk (clk),
        .en  (en),
        .a   (b4[IA]),
        .b   (b4[IB]),
        .p   (sqp[gu][ge])
      );
    end
  end

  // Stage 7: k = lambda*2trE - 2*mu, b^2 sums
  logic signed [KW-1:0]  k7;
  logic signed [SQW-1:0] sq7 [NL];

  always_ff @(posedge clk) begin
    if (en) begin
      k7 <= KW'(lt6) - (KW'($signed({1'b0, lame_mu})) << (2 * FB + 1));
      for (int u = 0; u < NL; u++) begin
        sq7[u] <= SQW'(sqp[u][0]) + SQW'(sqp[u][1]) + SQW'(sqp[u][2]);
      end
    end
  end

  // Stages 8-9: b*k and b^2*2mu
  logic signed [MU2W-1:0] mu2;
  logic signed [BKW-1:0]  bk9 [NL];
  logic signed [SMW-1:0]  sm9 [NL];

  assign mu2 = $signed({1'b0, lame_mu, 1'b0});

  for (genvar gu = 0; gu < NL; gu++) begin : g_num
    svk_wmul #(.AW(BW), .BW(KW)) u_bk (
      .clk (clk),
      .en  (en),
      .a   (b7[gu]),
      .b   (k7),
      .p   (bk9[gu])
    );
    svk_wmul #(.AW(SQW), .BW(MU2W)) u_sm (
      .clk (clk),
      .en  (en),
      .a   (sq7[gu]),
      .b   (mu2),
      .p   (sm9[gu])
    );
  end

  // Stage 10: numerators
  logic signed [NW-1:0] num10 [NL];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int u = 0; u < NL; u++) begin
        num10[u] <= NW'(bk9[u]) + NW'(sm9[u]);
      end
    end
  end

  // Stage 11: magnitude, overflow test against J, divider operands
  logic [MW-1:0]         mag_c [NL];
  logic [HW-1:0]         hi_c  [NL];
  logic [NL-1:0]         neg_c;
  logic [NL-1:0]         zero_c;
  logic [NL-1:0]         sat_c;

  always_comb begin
    for (int u = 0; u < NL; u++) begin
      neg_c[u]  = num10[u][NW-1];
      zero_c[u] = (num10[u] == '0);
      mag_c[u]  = MW'(neg_c[u] ? ~num10[u] : num10[u]);
      hi_c[u]   = mag_c[u][MW-1:SH+D-1];
      sat_c[u]  = (hi_c[u] >= HW'(jp[10])) && !zero_c[u];
    end
  end

  logic [QW-1:0]          j11;
  logic [NL-1:0][QW-1:0]  rem11;
  logic [NL-1:0][QW-1:0]  dvd11;
  logic [NL-1:0]          fneg  [11:PL];
  logic [NL-1:0]          fsat  [11:PL];
  logic [NL-1:0]          fzero [11:PL];

  always_ff @(posedge clk) begin
    if (en) begin
      j11 <= jp[10];
      for (int u = 0; u < NL; u++) begin
        rem11[u] <= hi_c[u][QW-1:0];
        dvd11[u] <= mag_c[u][SH+D-2:SH];
      end
      fneg[11]  <= neg_c;
      fsat[11]  <= sat_c;
      fzero[11] <= zero_c;
      for (int s = 12; s <= PL; s++) begin
        fneg[s]  <= fneg[s-1];
        fsat[s]  <= fsat[s-1];
        fzero[s] <= fzero[s-1];
      end
    end
  end

  // Stages 12 .. PL: quotient bits
  logic [NL-1:0][QW-1:0] qd;

  svk_div #(.DATA_WIDTH(D)) u_div (
    .clk  (clk),
    .en   (en),
    .j0   (j11),
    .rem0 (rem11),
    .dvd0 (dvd11),
    .q    (qd)
  );

  // Final rounding and clipping
  logic [NL-1:0][D-1:0] res;
  logic                 res_sat;

  always_comb begin
    for (int u = 0; u < NL; u++) begin
      if (fzero[PL][u]) begin
        res[u] = '0;
      end else if (fsat[PL][u]) begin
        res[u] = fneg[PL][u] ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
      end else begin
        res[u] = fneg[PL][u] ? ~{1'b0, qd[u]} : {1'b0, qd[u]};
      end
    end
    res_sat = |fsat[PL];
  end

  // Output register and skid
  logic [NL-1:0][D-1:0] sig_o;
  logic                 sat_o;
  logic [NL-1:0][D-1:0] sig_s;
  logic                 sat_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (stress.ready) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end
    end else if (v[PL]) begin
      if (!out_v || stress.ready) begin
        out_v <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (stress.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (stress.ready) begin
        sig_o <= sig_s;
        sat_o <= sat_s;
      end
    end else if (v[PL]) begin
      if (!out_v || stress.ready) begin
        sig_o <= res;
        sat_o <= res_sat;
      end else begin
        sig_s <= res;
        sat_s <= res_sat;
      end
    end
  end

  assign stress.valid     = out_v;
  assign stress.sigma_xx  = sig_o[0];
  assign stress.sigma_yy  = sig_o[1];
  assign stress.sigma_zz  = sig_o[2];
  assign stress.sigma_xy  = sig_o[3];
  assign stress.sigma_yz  = sig_o[4];
  assign stress.sigma_xz  = sig_o[5];
  assign stress.saturated = sat_o;

  // Assertions
  `SVK_ASSERT_IMP(a_skid_needs_out, skid_v, out_v, "skid holds a beat with no output beat")
  `SVK_ASSERT_NXT(a_skid_drains, skid_v && stress.ready, out_v && !skid_v, "skid beat not moved")
  `SVK_ASSERT_IMP(a_zero_not_sat, v[PL], (fzero[PL] & fsat[PL]) == '0, "zero numerator clipped")

endmodule

>>> dv/svk_stress_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svk_stress_checker
// Watches the point, stress and APB traffic of the Cauchy stress block.
// Tracks lambda and mu from APB writes and computes the stress of every
// accepted point exactly. Compares each stress beat with the oldest
// computed one and counts failures.
// ----------------------------------------------------------------------------
module svk_stress_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  svk_point_if        pts,
  svk_stress_if       strs,
  output int          pending,
  output int          fail_count
);

  localparam int FB = svk_pkg::FRAC_BITS_DEF;

  typedef logic signed [383:0] wide_t;
  typedef struct packed {
    logic [5:0][31:0] sigma;
    logic             sat;
  } stress_t;

  stress_t            stress_q[$];
  logic signed [31:0] lambda_r;
  logic [30:0]        mu_r;

  string comp_name[6] = '{"sigma_xx", "sigma_yy", "sigma_zz",
                          "sigma_xy", "sigma_yz", "sigma_xz"};

  assign pending = stress_q.size();

  // Round toward minus infinity into Q16.16 and clip to range.
  function automatic logic [31:0] round_clip(wide_t num, logic [30:0] j, inout logic sat);
    logic [383:0] mag;
    logic [383:0] q;
    logic         neg;
    neg = num[383];
    if (j == 0) begin
      if (num == 0) return 32'd0;
      sat = 1'b1;
      return neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    mag = neg ? ~num : num;
    q   = (mag / {353'd0, j}) >> (3 * FB + 1);
    if ((q >> 31) != 0) begin
      sat = 1'b1;
      return neg ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return neg ? ~q[31:0] : q[31:0];
  endfunction

  function automatic stress_t cauchy_stress(logic [8:0][31:0] f, logic [30:0] j,
                                            logic signed [31:0] lam, logic [30:0] mu);
    wide_t   fw[9];
    wide_t   b[3][3];
    wide_t   tr, k, lw, mw, sq, num;
    stress_t r;
    logic    sat;
    sat = 1'b0;
    for (int i = 0; i < 9; i++) fw[i] = $signed(f[i]);
    for (int a = 0; a < 3; a++)
      for (int c = 0; c < 3; c++) begin
        b[a][c] = 0;
        for (int e = 0; e < 3; e++) b[a][c] += fw[a*3+e] * fw[c*3+e];
      end
    lw = lam;
    mw = {353'd0, mu};
    tr = b[0][0] + b[1][1] + b[2][2] - (wide_t'(3) << (2 * FB));
    k  = lw * tr - (mw << (2 * FB + 1));
    for (int i = 0; i < svk_pkg::NL; i++) begin
      sq = 0;
      for (int e = 0; e < 3; e++) sq += b[svk_pkg::ROW[i]][e] * b[e][svk_pkg::COL[i]];
      num = b[svk_pkg::ROW[i]][svk_pkg::COL[i]] * k + sq * (mw + mw);
      r.sigma[i] = round_clip(num, j, sat);
    end
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    logic [8:0][31:0] f;
    stress_t          got, want;
    if (rst) begin
      lambda_r   <= '0;
      mu_r       <= '0;
      fail_count <= 0;
      stress_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == svk_pkg::REG_LAMBDA) lambda_r <= pwdata;
        else mu_r <= pwdata[30:0];
      end
      if (pts.valid && pts.ready) begin
        f = {pts.f_33, pts.f_32, pts.f_31, pts.f_23, pts.f_22, pts.f_21,
             pts.f_13, pts.f_12, pts.f_11};
        stress_q.push_back(cauchy_stress(f, pts.volume_ratio, lambda_r, mu_r));
      end
      if (strs.valid && strs.ready) begin
        got.sigma = {strs.sigma_xz, strs.sigma_yz, strs.sigma_xy,
                     strs.sigma_zz, strs.sigma_yy, strs.sigma_xx};
        got.sat   = strs.saturated;
        if (stress_q.size() == 0) begin
          $error("stress beat with no point outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = stress_q.pop_front();
          if (got != want) fail_count <= fail_count + 1;
          for (int i = 0; i < svk_pkg::NL; i++)
            if (got.sigma[i] !== want.sigma[i])
              $error("%s: expected %0d, got %0d", comp_name[i],
                     $signed(want.sigma[i]), $signed(got.sigma[i]));
          if (got.sat !== want.sat)
            $error("saturated: expected %0b, got %0b", want.sat, got.sat);
        end
      end
    end
  end
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the Cauchy stress block: several lambda/mu settings, a
// directed set of deformation gradients, then bursty random points with a
// stalling receiver. The checker does the comparison.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int   LATENCY  = svk_pkg::DATA_WIDTH_DEF + 11;
  localparam int   IDLE_MAX = 20000;
  localparam int   N_PHASE  = 6;
  localparam int   N_RAND   = 330;
  localparam logic [31:0] ONE = 32'h0100_0000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          pending, fail_count;
  int          idle_cycles;
  int          rdy_left, rdy_mode;

  svk_point_if  pts ();
  svk_stress_if strs ();

  svk_cauchy_stress i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .points(pts), .stress(strs)
  );

  svk_stress_checker i_checker (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .pready(pready), .paddr(paddr), .pwdata(pwdata), .pts(pts), .strs(strs),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: pick a stall pattern per stretch, including stretches with none.
  always @(posedge clk) begin
    if (rst) begin
      strs.ready <= 1'b0;
      rdy_left   <= 0;
      rdy_mode   <= 0;
    end else begin
      if (rdy_left == 0) begin
        rdy_left <= $urandom_range(16, 128);
        rdy_mode <= $urandom_range(0, 3);
      end else begin
        rdy_left <= rdy_left - 1;
      end
      case (rdy_mode)
        0: strs.ready <= 1'b1;
        1: strs.ready <= ($urandom_range(0, 3) != 0);
        2: strs.ready <= ($urandom_range(0, 3) == 0);
        default: strs.ready <= ~strs.ready;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (pts.valid && pts.ready) || (strs.valid && strs.ready) ||
        (!pts.valid && pending == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [0:0] idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Present one point; return once it is accepted. Valid stays high.
  task automatic send_point(logic [8:0][31:0] f, logic [30:0] j);
    pts.valid        <= 1'b1;
    pts.f_11         <= f[0];
    pts.f_12         <= f[1];
    pts.f_13         <= f[2];
    pts.f_21         <= f[3];
    pts.f_22         <= f[4];
    pts.f_23         <= f[5];
    pts.f_31         <= f[6];
    pts.f_32         <= f[7];
    pts.f_33         <= f[8];
    pts.volume_ratio <= j;
    @(posedge clk);
    while (!pts.ready) @(posedge clk);
  endtask

  function automatic logic [8:0][31:0] identity();
    logic [8:0][31:0] f;
    f = '0;
    f[0] = ONE;
    f[4] = ONE;
    f[8] = ONE;
    return f;
  endfunction

  // Leaves valid high; the random stream that follows takes over the channel.
  task automatic send_directed();
    logic [8:0][31:0] f;
    send_point(identity(), ONE[30:0]);
    send_point('0, ONE[30:0]);
    send_point('0, 31'd0);
    send_point(identity(), 31'd0);
    f = identity();
    f[1] = 32'h0080_0000;
    send_point(f, ONE[30:0]);
    f = identity();
    f[0] = 32'h0180_0000;
    f[5] = 32'hff80_0000;
    send_point(f, 31'h0180_0000);
    f = identity();
    f[4] = 32'hff00_0000;
    send_point(f, ONE[30:0]);
    send_point({9{32'h7fff_ffff}}, ONE[30:0]);
    send_point({9{32'h8000_0000}}, ONE[30:0]);
    send_point({9{32'h7fff_ffff}}, 31'h7fff_ffff);
    send_point({9{32'h8000_0000}}, 31'd1);
    send_point(identity(), 31'd1);
    send_point(identity(), 31'h7fff_ffff);
    send_point({9{32'hffff_ffff}}, ONE[30:0]);
    send_point({9{32'h0000_0001}}, 31'd1);
    f = '0;
    f[2] = 32'h0100_0000;
    f[3] = 32'h0100_0000;
    f[7] = 32'hff00_0000;
    send_point(f, ONE[30:0]);
  endtask

  function automatic logic [30:0] rand_j();
    case ($urandom_range(0, 9))
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 15));
      default: return 31'(ONE + $signed($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000);
    endcase
  endfunction

  task automatic send_random(int n);
    logic [8:0][31:0] f;
    int               burst;
    int               mode;
    burst = 0;
    for (int it = 0; it < n; it++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          pts.valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        burst = $urandom_range(1, 24);
      end
      burst--;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
        case (mode)
          0, 1: f[i] = $urandom;
          2: f[i] = $signed($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
          default: f[i] = ((i % 4 == 0) ? ONE : 32'd0) +
                          $signed($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
        endcase
      end
      send_point(f, rand_j());
    end
    pts.valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);
  endtask

  initial begin
    logic [31:0] lam_set[N_PHASE];
    logic [31:0] mu_set[N_PHASE];
    lam_set = '{32'd0, 32'h0064_0000, 32'h8000_0000, 32'h7fff_ffff,
                32'hffff_ffff, 32'h0000_0000};
    mu_set  = '{32'd0, 32'h0032_0000, 32'h7fff_ffff, 32'h0000_0000,
                32'h0000_0001, 32'h7fff_ffff};
    lam_set[5] = $urandom;
    mu_set[5]  = $urandom_range(0, 32'h7fff_ffff);
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    pts.valid <= 1'b0;
    pts.f_11 <= '0; pts.f_12 <= '0; pts.f_13 <= '0;
    pts.f_21 <= '0; pts.f_22 <= '0; pts.f_23 <= '0;
    pts.f_31 <= '0; pts.f_32 <= '0; pts.f_33 <= '0;
    pts.volume_ratio <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < N_PHASE; ph++) begin
      // phase 0 runs on the reset values
      if (ph != 0) begin
        reg_write(svk_pkg::REG_LAMBDA, lam_set[ph]);
        reg_write(svk_pkg::REG_MU, mu_set[ph]);
        @(posedge clk);
      end
      if (ph == 1) send_directed();
      send_random(N_RAND);
      drain();
    end
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
